// ----- rtl/core/mb2yuv_pkg.sv -----
package mb2yuv_pkg;

	localparam int TILE_SIZE = 16;

	// pixel_format codes; the unused code behaves as linear UV pairs
	localparam logic [1:0] FMT_TILED = 2'd0;
	localparam logic [1:0] FMT_UV    = 2'd1;
	localparam logic [1:0] FMT_VU    = 2'd2;

	localparam logic [1:0] PL_Y = 2'd0;
	localparam logic [1:0] PL_U = 2'd1;
	localparam logic [1:0] PL_V = 2'd2;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BIG = 2'd1;
	localparam logic [1:0] ST_LEN = 2'd2;

	localparam logic [2:0] REG_FORMAT        = 3'd0;
	localparam logic [2:0] REG_WIDTH         = 3'd1;
	localparam logic [2:0] REG_HEIGHT        = 3'd2;
	localparam logic [2:0] REG_LUMA_STRIDE   = 3'd3;
	localparam logic [2:0] REG_CHROMA_STRIDE = 3'd4;

	localparam logic [12:0] DIM_MIN = 13'd2;
	localparam logic [12:0] DIM_MAX = 13'd4096;

	// linear modes refuse frames above this size
	localparam logic [12:0] LIN_MAX_W = 13'd720;
	localparam logic [12:0] LIN_MAX_H = 13'd576;

	localparam logic [24:0] OFFSET_MAX = '1;

	localparam logic [1:0]  RST_FORMAT        = FMT_TILED;
	localparam logic [12:0] RST_WIDTH         = 13'd720;
	localparam logic [12:0] RST_HEIGHT        = 13'd576;
	localparam logic [13:0] RST_LUMA_STRIDE   = 14'd720;
	localparam logic [12:0] RST_CHROMA_STRIDE = 13'd360;
	// 720 * 576 and 360 * 288 * 2
	localparam logic [24:0] RST_YSIZE = 25'd414720;
	localparam logic [24:0] RST_UVTOT = 25'd207360;

	typedef struct packed {
		logic [1:0]  fmt;
		logic [12:0] width;      // clamped
		logic [12:0] height;     // clamped
		logic [13:0] luma_stride;
		logic [12:0] chroma_stride;
		logic [24:0] ysize;
		logic [24:0] uvtot;
		logic        big;
	} cfg_t;

	// offset = mul_a * mul_b + add_term
	typedef struct packed {
		logic [11:0] mul_a;
		logic [13:0] mul_b;
		logic [23:0] add_term;
		logic [1:0]  plane;
		logic        we;
		logic [1:0]  status;
	} op_t;

	function automatic logic [12:0] clamp_dim(input logic [12:0] v);
		if (v < DIM_MIN) return DIM_MIN;
		if (v > DIM_MAX) return DIM_MAX;
		return v;
	endfunction

endpackage

// ----- rtl/core/mb2yuv_walker.sv -----
module mb2yuv_walker (
	input  logic               clk,
	input  logic               arst_n,
	input  mb2yuv_pkg::cfg_t   cfg,
	input  logic               accept,
	input  logic               last_byte,
	output mb2yuv_pkg::op_t    op,
	output logic               at_start
);

	logic        chroma_q;
	logic [7:0]  bit_q;
	logic [8:0]  col_q;
	logic [7:0]  row_q;
	logic [23:0] lin_q;

	logic        chroma_n;
	logic [7:0]  bit_n;
	logic [8:0]  col_n;
	logic [7:0]  row_n;
	logic [23:0] lin_n;

	logic [8:0]  lcols, lrows, ccols, crows;
	logic [9:0]  col_inc;
	logic [8:0]  row_inc;
	logic [24:0] lin_inc;
	logic [3:0]  r, c;
	logic        bit_last, ends_ok, vu;

	assign lcols = 9'((cfg.width + 13'd15) >> 4);
	assign lrows = 9'((cfg.height + 13'd15) >> 4);
	assign ccols = 9'(((cfg.width >> 1) + 13'd7) >> 3);
	assign crows = 9'(((cfg.height >> 1) + 13'd15) >> 4);

	assign r        = bit_q[7:4];
	assign c        = bit_q[3:0];
	assign bit_last = (bit_q == 8'hFF);
	assign col_inc  = {1'b0, col_q} + 10'd1;
	assign row_inc  = {1'b0, row_q} + 9'd1;
	assign lin_inc  = {1'b0, lin_q} + 25'd1;
	assign vu       = (cfg.fmt == mb2yuv_pkg::FMT_VU);

	always_comb begin
		op       = '0;
		op.plane = mb2yuv_pkg::PL_Y;
		op.status = mb2yuv_pkg::ST_OK;
		ends_ok  = 1'b0;
		chroma_n = chroma_q;
		bit_n    = bit_q;
		col_n    = col_q;
		row_n    = row_q;
		lin_n    = lin_q;
		if (cfg.fmt == mb2yuv_pkg::FMT_TILED) begin
			if (!chroma_q) begin
				op.mul_a    = {row_q, r};
				op.mul_b    = cfg.luma_stride;
				op.add_term = 24'({col_q, c});
				op.we       = 1'b1;
				bit_n       = bit_q + 8'd1;
				if (bit_last) begin
					if (col_inc >= {1'b0, lcols}) begin
						col_n = '0;
						if (row_inc >= lrows) begin
							row_n    = '0;
							chroma_n = 1'b1;
						end else begin
							row_n = row_inc[7:0];
						end
					end else begin
						col_n = col_inc[8:0];
					end
				end
			end else if ({1'b0, row_q} < crows) begin
				// U,V pairs: even column byte is U
				op.plane    = c[0] ? mb2yuv_pkg::PL_V : mb2yuv_pkg::PL_U;
				op.mul_a    = {row_q, r};
				op.mul_b    = {1'b0, cfg.chroma_stride};
				op.add_term = 24'({col_q, c[3:1]});
				op.we       = 1'b1;
				ends_ok     = bit_last && (col_inc >= {1'b0, ccols}) && (row_inc >= crows);
				bit_n       = bit_q + 8'd1;
				if (bit_last) begin
					if (col_inc >= {1'b0, ccols}) begin
						col_n = '0;
						row_n = row_inc[7:0];
					end else begin
						col_n = col_inc[8:0];
					end
				end
			end
		end else begin
			if (!chroma_q) begin
				op.add_term = lin_q;
				op.we       = 1'b1;
				if (lin_inc >= cfg.ysize) begin
					lin_n    = '0;
					chroma_n = 1'b1;
				end else begin
					lin_n = lin_inc[23:0];
				end
			end else if ({1'b0, lin_q} < cfg.uvtot) begin
				op.plane    = (lin_q[0] ^ vu) ? mb2yuv_pkg::PL_V : mb2yuv_pkg::PL_U;
				op.add_term = {1'b0, lin_q[23:1]};
				op.we       = 1'b1;
				ends_ok     = (lin_inc == cfg.uvtot);
				lin_n       = lin_inc[23:0];
			end
			if (cfg.big) begin
				op.we     = 1'b0;
				op.status = mb2yuv_pkg::ST_BIG;
			end
		end
		// end of frame: length check, then back to the start
		if (last_byte) begin
			if (!ends_ok) op.status = mb2yuv_pkg::ST_LEN;
			chroma_n = 1'b0;
			bit_n    = '0;
			col_n    = '0;
			row_n    = '0;
			lin_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_q <= 1'b0;
			bit_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
			lin_q    <= '0;
		end else if (accept) begin
			chroma_q <= chroma_n;
			bit_q    <= bit_n;
			col_q    <= col_n;
			row_q    <= row_n;
			lin_q    <= lin_n;
		end
	end

	assign at_start = !chroma_q && (bit_q == '0) && (col_q == '0) && (row_q == '0)
		&& (lin_q == '0);

endmodule

// ----- rtl/core/macroblock_tile_to_planar_yuv_core.sv -----
// Routes each byte of a raw 4:2:0 frame to a plane (Y, U, V) and a byte offset
// in that plane, de-tiling 16x16 macroblock tiles or splitting linear UV/VU pairs.
// One byte is accepted every clock while in_ready is high; the byte and its walker
// counters go into the input register, then the offset multiply, then add and
// saturate into the output register. While a result waits at the output
// the input still takes words until the two stages behind it are full. The tile
// counters are updated in the accept cycle, which is the loop that sets the
// one-byte rate.
// Registers may be written only between bytes; a write takes effect on the next byte.
module macroblock_tile_to_planar_yuv_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pixel_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  dest_plane,
	output logic [24:0] dest_offset,
	output logic [7:0]  dest_value,
	output logic        write_enable,
	output logic [1:0]  status,
	output logic        frame_done
);

	// configuration
	logic [1:0]  fmt_q, fmt_n;
	logic [12:0] width_q, width_n, height_q, height_n;
	logic [13:0] lstride_q, lstride_n;
	logic [12:0] cstride_q, cstride_n;
	logic [24:0] ysize_q, uvtot_q;
	logic [12:0] w_cl_n, h_cl_n;
	logic [25:0] yprod;
	logic [23:0] uvprod;
	mb2yuv_pkg::cfg_t cfg;

	always_comb begin
		fmt_n     = fmt_q;
		width_n   = width_q;
		height_n  = height_q;
		lstride_n = lstride_q;
		cstride_n = cstride_q;
		if (cfg_write) begin
			unique case (cfg_index)
				mb2yuv_pkg::REG_FORMAT:        fmt_n     = cfg_data[1:0];
				mb2yuv_pkg::REG_WIDTH:         width_n   = cfg_data[12:0];
				mb2yuv_pkg::REG_HEIGHT:        height_n  = cfg_data[12:0];
				mb2yuv_pkg::REG_LUMA_STRIDE:   lstride_n = cfg_data;
				mb2yuv_pkg::REG_CHROMA_STRIDE: cstride_n = cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// frame sizes follow the register values written in the same cycle
	assign w_cl_n = mb2yuv_pkg::clamp_dim(width_n);
	assign h_cl_n = mb2yuv_pkg::clamp_dim(height_n);
	assign yprod  = w_cl_n * h_cl_n;
	assign uvprod = w_cl_n[12:1] * h_cl_n[12:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= mb2yuv_pkg::RST_FORMAT;
			width_q   <= mb2yuv_pkg::RST_WIDTH;
			height_q  <= mb2yuv_pkg::RST_HEIGHT;
			lstride_q <= mb2yuv_pkg::RST_LUMA_STRIDE;
			cstride_q <= mb2yuv_pkg::RST_CHROMA_STRIDE;
			ysize_q   <= mb2yuv_pkg::RST_YSIZE;
			uvtot_q   <= mb2yuv_pkg::RST_UVTOT;
		end else begin
			fmt_q     <= fmt_n;
			width_q   <= width_n;
			height_q  <= height_n;
			lstride_q <= lstride_n;
			cstride_q <= cstride_n;
			ysize_q   <= yprod[24:0];
			uvtot_q   <= {uvprod, 1'b0};
		end
	end

	always_comb begin
		cfg.fmt           = fmt_q;
		cfg.width         = mb2yuv_pkg::clamp_dim(width_q);
		cfg.height        = mb2yuv_pkg::clamp_dim(height_q);
		cfg.luma_stride   = lstride_q;
		cfg.chroma_stride = cstride_q;
		cfg.ysize         = ysize_q;
		cfg.uvtot         = uvtot_q;
		cfg.big           = (width_q > mb2yuv_pkg::LIN_MAX_W)
			|| (height_q > mb2yuv_pkg::LIN_MAX_H);
	end

	// pipeline control
	logic v_s1, v_s2, out_valid_q;
	logic s1_en, s2_en, out_en, accept, walk_start;

	assign out_en = !out_valid_q || out_ready;
	assign s2_en  = !v_s2 || out_en;
	assign s1_en  = !v_s1 || s2_en;
	assign in_ready = s1_en;
	assign accept = in_valid && s1_en;

	mb2yuv_pkg::op_t op;

	mb2yuv_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.last_byte (last_byte),
		.op        (op),
		.at_start  (walk_start)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en) v_s1 <= in_valid;
			if (s2_en) v_s2 <= v_s1;
			if (out_en) out_valid_q <= v_s2;
		end
	end

	// datapath
	mb2yuv_pkg::op_t op_s1;
	logic [7:0]  value_s1, value_s2;
	logic        last_s1, last_s2;
	logic [25:0] prod_s2;
	logic [23:0] add_s2;
	logic [1:0]  plane_s2, status_s2;
	logic        we_s2;
	logic [26:0] sum;
	logic        ovf;

	logic [1:0]  plane_q, status_q;
	logic [24:0] offset_q;
	logic [7:0]  value_q;
	logic        we_q, done_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			value_s1 <= pixel_byte;
			last_s1  <= last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && v_s1) begin
			prod_s2   <= op_s1.mul_a * op_s1.mul_b;
			add_s2    <= op_s1.add_term;
			plane_s2  <= op_s1.plane;
			we_s2     <= op_s1.we;
			status_s2 <= op_s1.status;
			value_s2  <= value_s1;
			last_s2   <= last_s1;
		end
	end

	assign sum = {1'b0, prod_s2} + {3'b0, add_s2};
	assign ovf = sum > {2'b0, mb2yuv_pkg::OFFSET_MAX};

	always_ff @(posedge clk) begin
		if (out_en && v_s2) begin
			plane_q  <= plane_s2;
			offset_q <= ovf ? mb2yuv_pkg::OFFSET_MAX : sum[24:0];
			we_q     <= we_s2 && !ovf;
			status_q <= status_s2;
			value_q  <= value_s2;
			done_q   <= last_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign dest_plane   = plane_q;
	assign dest_offset  = offset_q;
	assign dest_value   = value_q;
	assign write_enable = we_q;
	assign status       = status_q;
	assign frame_done   = done_q;

`ifndef SYNTHESIS
	a_we_not_big: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> status != mb2yuv_pkg::ST_BIG)
		else $error("write enabled on an oversized frame");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> walk_start)
		else $error("walker not back at frame start after last word");

	a_dropped_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable && status == mb2yuv_pkg::ST_OK |->
		dest_offset == '0 || dest_offset == mb2yuv_pkg::OFFSET_MAX)
		else $error("suppressed write with unexpected offset");
`endif

endmodule
